/* design/fir_df_pkg.sv */
// Shared types and constants of the direct-form FIR filter.
package fir_df_pkg;

    // Fixed field widths of the stream and the register file
    localparam int COEF_IDX_W  = 10;
    localparam int NUM_TAPS_W  = 11;
    localparam int COEF_FRAC   = 16;

    // APB register map (register index = paddr[3:2])
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam logic [1:0] REG_NUM_TAPS = 2'd0;
    localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET = 11'd1024;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic {
        CMD_COEF   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MAC,
        ST_ROUND,
        ST_OUT
    } back_state_t;

endpackage

/* design/fir_filter_direct_form_top.sv */
// Top level of the direct-form FIR filter: stream ports, APB register, front, queue and MAC engine.
//
// Direct-form FIR filter with one shared multiply-accumulate. A stream transfer with
// tuser=0 writes a coefficient into the store (ignored when the index is at or beyond
// MAX_TAPS) and gives no result; one with tuser=1 pushes a sample into the circular delay
// line and gives one filtered sample: the sum of products with Q2.16 coefficients, rounded,
// shifted right by 16 and clipped to SAMPLE_BITS, with the clip flag on m_tuser. With
// n = min(num_taps, MAX_TAPS, samples pushed since reset), a sample takes n products from
// the single multiplier, which reads one coefficient and one delayed sample per cycle behind
// a two-stage read and multiply pipeline; a stalled result channel holds the engine in its
// output state. A command passes the input register and the queue before the engine takes
// it. The engine takes a coefficient write in its idle state. Delay entries never written
// count as zero, tracked by a fill count, so no clearing pass follows reset. Every
// coefficient a filter step uses must be written first. A four-entry command queue lets
// input transfers keep arriving while the engine works, and a result register holds the
// output while the next sample is processed.
// Write num_taps at byte address 0 only while the filter is idle.
module fir_filter_direct_form_top #(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    localparam int S_TDATA_W  =
        ((fir_df_pkg::COEF_IDX_W + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fir_df_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fir_df_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fir_df_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,  // coef_index, coef_value, sample_in
    input  logic [0:0]                        s_tuser,  // op
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata,  // sample_out
    output logic [0:0]                        m_tuser   // saturated
);
    import fir_df_pkg::*;

    localparam int VAL_W = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
    localparam int CMD_W = 1 + COEF_IDX_W + VAL_W;

    logic [NUM_TAPS_W-1:0]  num_taps_reg;
    logic                   cfg_write;
    logic                   front_valid;
    logic                   front_ready;
    logic [CMD_W-1:0]       front_data;
    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [CMD_W-1:0]       cmd_data;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic                   out_sat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[3:2] == REG_NUM_TAPS);
    assign prdata    = (paddr[3:2] == REG_NUM_TAPS) ? APB_DATA_W'(num_taps_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= NUM_TAPS_RESET;
        end else if (cfg_write) begin
            num_taps_reg <= pwdata[NUM_TAPS_W-1:0];
        end
    end

    fir_df_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .TDATA_W     (S_TDATA_W),
        .VAL_W       (VAL_W),
        .CMD_W       (CMD_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd_data  (front_data)
    );

    fir_df_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd_data)
    );

    fir_df_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .VAL_W       (VAL_W),
        .CMD_W       (CMD_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .num_taps   (num_taps_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_sat    (out_sat)
    );

    assign m_tdata = M_TDATA_W'(out_sample);
    assign m_tuser = out_sat;

endmodule

/* design/fir_df_front.sv */
// Input stage: accepts stream transfers, drops out-of-range coefficient writes, packs commands.
module fir_df_front #(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int TDATA_W     = 48,
    parameter int VAL_W       = 18,
    parameter int CMD_W       = 29
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [0:0]         s_tuser,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output logic [CMD_W-1:0]   cmd_data
);
    import fir_df_pkg::*;

    logic                  hold_valid_reg, hold_valid_next;
    logic [CMD_W-1:0]      hold_data_reg;
    logic                  accept;
    logic                  keep;
    cmd_kind_t             kind;
    logic [COEF_IDX_W-1:0] idx;
    logic [COEF_BITS-1:0]  coef;
    logic [SAMPLE_BITS-1:0] sample;
    logic [VAL_W-1:0]      val;

    always_comb begin
        kind   = cmd_kind_t'(s_tuser);
        idx    = s_tdata[COEF_IDX_W-1:0];
        coef   = s_tdata[COEF_IDX_W +: COEF_BITS];
        sample = s_tdata[COEF_IDX_W+COEF_BITS +: SAMPLE_BITS];
        val    = (kind == CMD_SAMPLE) ? VAL_W'(sample) : VAL_W'(coef);
        // drop coefficient writes that land beyond the store
        keep   = (kind == CMD_SAMPLE) || (32'(idx) < MAX_TAPS);
        s_tready = !hold_valid_reg || cmd_ready;
        accept = s_tvalid && s_tready;
        if (accept && keep) begin
            hold_valid_next = 1'b1;
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            hold_data_reg <= {kind, idx, val};
        end
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd_data  = hold_data_reg;

endmodule

/* design/fir_df_queue.sv */
// Short command FIFO that decouples the input stage from the MAC engine.
module fir_df_queue #(
    parameter int DATA_W = 29
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import fir_df_pkg::*;

    logic [DATA_W-1:0]      slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;

    always_comb begin
        push_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
        pop_valid   = (count_reg != '0);
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
        pop_data = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/fir_df_back.sv */
// MAC engine: coefficient store, circular delay line, shared multiply-accumulate, round and clip.
module fir_df_back #(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int VAL_W       = 18,
    parameter int CMD_W       = 29
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [fir_df_pkg::NUM_TAPS_W-1:0] num_taps,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [CMD_W-1:0]                  cmd_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SAMPLE_BITS-1:0]            out_sample,
    output logic                              out_sat
);
    import fir_df_pkg::*;

    localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int CMP_W   = ((NUM_TAPS_W > CNT_W) ? NUM_TAPS_W : CNT_W) + 1;
    localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_RAW = PROD_W + CNT_W + 1;
    localparam int ACC_MIN = SAMPLE_BITS + COEF_FRAC + 1;
    localparam int ACC_W   = (ACC_RAW > ACC_MIN) ? ACC_RAW : ACC_MIN;
    localparam int SH_W    = ACC_W - COEF_FRAC;

    back_state_t state_reg, state_next;

    logic [COEF_BITS-1:0]   coef_mem  [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS];

    logic [TAP_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        taps_reg, taps_next;
    logic [CNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic [TAP_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    prod_valid_reg;
    logic [COEF_BITS-1:0]    coef_q_reg;
    logic [SAMPLE_BITS-1:0]  samp_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SH_W-1:0]         sh_reg, sh_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]  out_sample_reg, out_sample_next;
    logic                    out_sat_reg, out_sat_next;

    cmd_kind_t              cmd_kind;
    logic [COEF_IDX_W-1:0]  cmd_idx;
    logic [VAL_W-1:0]       cmd_val;
    logic                   coef_we;
    logic                   delay_we;
    logic                   issue;
    logic [TAP_W-1:0]       pos_adv;
    logic [CMP_W-1:0]       lim_a;
    logic [CMP_W-1:0]       lim_b;
    logic signed [ACC_W-1:0] rnd;
    logic [SH_W-SAMPLE_BITS:0] upper;
    logic                   in_range;
    logic                   out_free;

    always_comb begin
        cmd_kind = cmd_kind_t'(cmd_data[CMD_W-1]);
        cmd_idx  = cmd_data[VAL_W +: COEF_IDX_W];
        cmd_val  = cmd_data[VAL_W-1:0];
        pos_adv  = (pos_reg == TAP_W'(MAX_TAPS - 1)) ? '0 : pos_reg + 1'b1;
        out_free = !out_valid_reg || out_ready;

        // active taps: register value, clipped to the store and to samples seen
        lim_a = CMP_W'(num_taps);
        if (lim_a > CMP_W'(MAX_TAPS)) begin
            lim_a = CMP_W'(MAX_TAPS);
        end
        lim_b = (lim_a > CMP_W'(fill_reg)) ? CMP_W'(fill_reg) : lim_a;

        rnd   = acc_reg + (ACC_W'(1) << (COEF_FRAC - 1));
        upper = sh_reg[SH_W-1:SAMPLE_BITS-1];
        in_range = (&upper) || !(|upper);

        state_next      = state_reg;
        cmd_ready       = 1'b0;
        coef_we         = 1'b0;
        delay_we        = 1'b0;
        issue           = 1'b0;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        taps_next       = taps_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        acc_next        = acc_reg;
        sh_next         = sh_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_sat_next    = out_sat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (cmd_kind == CMD_SAMPLE) begin
                        delay_we = 1'b1;
                        pos_next = pos_adv;
                        if (fill_reg != CNT_W'(MAX_TAPS)) begin
                            fill_next = fill_reg + 1'b1;
                        end
                        state_next = ST_START;
                    end else begin
                        coef_we = 1'b1;
                    end
                end
            end
            ST_START: begin
                taps_next      = CNT_W'(lim_b);
                issue_cnt_next = '0;
                rd_ptr_next    = pos_reg;
                acc_next       = '0;
                state_next     = ST_MAC;
            end
            ST_MAC: begin
                issue = (issue_cnt_reg < taps_reg);
                if (issue) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_ptr_next = (rd_ptr_reg == '0) ? TAP_W'(MAX_TAPS - 1)
                                                     : rd_ptr_reg - 1'b1;
                end
                if (prod_valid_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                // leave once the read and multiply stages have drained
                if (!issue && !rd_valid_reg && !prod_valid_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                sh_next    = rnd[ACC_W-1:COEF_FRAC];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_sat_next   = !in_range;
                    if (in_range) begin
                        out_sample_next = sh_reg[SAMPLE_BITS-1:0];
                    end else if (sh_reg[SH_W-1]) begin
                        out_sample_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    end else begin
                        out_sample_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        rd_valid_next = issue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            fill_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            rd_valid_reg   <= rd_valid_next;
            prod_valid_reg <= rd_valid_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        taps_reg       <= taps_next;
        issue_cnt_reg  <= issue_cnt_next;
        rd_ptr_reg     <= rd_ptr_next;
        acc_reg        <= acc_next;
        sh_reg         <= sh_next;
        out_sample_reg <= out_sample_next;
        out_sat_reg    <= out_sat_next;
        prod_reg       <= $signed(coef_q_reg) * $signed(samp_q_reg);
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[TAP_W'(cmd_idx)] <= cmd_val[COEF_BITS-1:0];
        end
        coef_q_reg <= coef_mem[issue_cnt_reg[TAP_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (delay_we) begin
            delay_mem[pos_adv] <= cmd_val[SAMPLE_BITS-1:0];
        end
        samp_q_reg <= delay_mem[rd_ptr_reg];
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_sat    = out_sat_reg;

endmodule

/* bench/fir_df_monitor.sv */
// Result predictor and checker of the FIR filter: watches the APB port and both streams.
module fir_df_monitor #(
    parameter int MAX_TAPS  = 1024,
    parameter int S_TDATA_W = 48,
    parameter int M_TDATA_W = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fir_df_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fir_df_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [fir_df_pkg::APB_DATA_W-1:0] prdata,
    input  logic                              pready,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,  // coef_index, coef_value, sample_in
    input  logic [0:0]                        s_tuser,  // op
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [M_TDATA_W-1:0]              m_tdata,  // sample_out
    input  logic [0:0]                        m_tuser,  // saturated
    output int                                errors,
    output int                                pending,
    output int                                results,
    output int                                clipped
);
    import fir_df_pkg::*;

    typedef struct packed {
        logic signed [15:0] level;
        logic               clip;
    } filtered_t;

    logic signed [15:0]   delay_line [0:1023];
    logic signed [17:0]   coef_store [0:1023];
    logic [9:0]           newest;
    logic [NUM_TAPS_W-1:0] tap_count;
    filtered_t            expected_outputs [$];
    filtered_t            head;

    initial begin
        errors  = 0;
        pending = 0;
        results = 0;
        clipped = 0;
    end

    // Push one sample into the delay line and return the rounded, clipped sum
    function automatic filtered_t push_and_filter(logic signed [15:0] smp);
        longint     acc;
        longint     y;
        int         taps;
        logic [9:0] p;
        filtered_t  r;
        newest = newest + 1'b1;
        delay_line[newest] = smp;
        taps = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
        acc = 0;
        p = newest;
        for (int m = 0; m < taps; m++) begin
            acc += longint'(coef_store[m]) * longint'(delay_line[p]);
            p = p - 1'b1;
        end
        y = (acc + 64'sd32768) >>> COEF_FRAC;
        if (y > 32767) begin
            r.level = 16'sh7FFF;
            r.clip  = 1'b1;
        end else if (y < -32768) begin
            r.level = 16'sh8000;
            r.clip  = 1'b1;
        end else begin
            r.level = 16'(y);
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 1024; i++) begin
                delay_line[i] = '0;
                coef_store[i] = '0;
            end
            newest    = '0;
            tap_count = NUM_TAPS_RESET;
            expected_outputs.delete();
        end else begin
            if (psel && penable && pready && paddr[3:2] == REG_NUM_TAPS) begin
                if (pwrite) begin
                    tap_count = pwdata[NUM_TAPS_W-1:0];
                end else if (prdata !== APB_DATA_W'(tap_count)) begin
                    $error("num_taps readback: expected %0d, got %0d", tap_count, prdata);
                    errors++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (cmd_kind_t'(s_tuser[0]) == CMD_COEF)
                    coef_store[s_tdata[9:0]] = s_tdata[27:10];
                else
                    expected_outputs.push_back(push_and_filter(s_tdata[43:28]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $error("sample_out %0d arrived with no sample waiting",
                           $signed(m_tdata[15:0]));
                    errors++;
                end else begin
                    head = expected_outputs.pop_front();
                    if (m_tdata[15:0] !== head.level) begin
                        $error("sample_out: expected %0d, got %0d",
                               head.level, $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tuser[0] !== head.clip) begin
                        $error("saturated: expected %0d, got %0d", head.clip, m_tuser[0]);
                        errors++;
                    end
                    results++;
                    if (head.clip)
                        clipped++;
                end
            end
            pending = expected_outputs.size();
        end
    end

endmodule

/* bench/tb.sv */
// Testbench top: drives the FIR filter's APB and stream ports and reports the verdict.
module tb;
    import fir_df_pkg::*;

    localparam int MAX_TAPS  = 1024;
    localparam int S_TDATA_W = ((COEF_IDX_W + 18 + 16 + 7) / 8) * 8;
    localparam int M_TDATA_W = 16;
    localparam logic [1:0] REG_UNMAPPED_LO = 2'd1;
    localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // coef_index, coef_value, sample_in
    logic [0:0]            s_tuser  = '0;  // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;        // sample_out
    logic [0:0]            m_tuser;        // saturated

    int          errors, pending, results, clipped;
    int          items    = 0;
    int          settings = 0;
    int          stall_left = 0;
    bit          calm     = 1'b0;
    bit          coef_known [0:1023];
    int unsigned taps_now = NUM_TAPS_RESET;
    int unsigned tap_plan [0:13];
    int unsigned n, eff, count, pick, guard;

    fir_filter_direct_form_top #(
        .MAX_TAPS   (MAX_TAPS),
        .SAMPLE_BITS(16),
        .COEF_BITS  (18)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    fir_df_monitor #(
        .MAX_TAPS (MAX_TAPS),
        .S_TDATA_W(S_TDATA_W),
        .M_TDATA_W(M_TDATA_W)
    ) mon (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .errors  (errors),
        .pending (pending),
        .results (results),
        .clipped (clipped)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[fir_filter_direct_form_top] ERROR");
        $finish;
    end

    // Stall the result channel in bursts of random length while not calm
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [17:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 18'h1FFFF;
            1:       return 18'h20000;
            2, 3:    return 18'($urandom);
            default: return 18'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // One input transfer; valid stays high on return so the next item can follow back to back
    task automatic send(cmd_kind_t op, logic [9:0] idx, logic [17:0] coef, logic [15:0] smp);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, smp, coef, idx};
        do @(posedge aclk); while (!s_tready);
        if (op == CMD_COEF)
            coef_known[idx] = 1'b1;
        items++;
    endtask

    task automatic apb_access(logic wr, logic [1:0] reg_idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain every pending result, then give queued coefficient writes time to retire
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_taps(int unsigned value);
        int unsigned live;
        live = (value > MAX_TAPS) ? MAX_TAPS : value;
        // every coefficient a filter step may use must be written first
        for (int i = 0; i < live; i++)
            if (!coef_known[i])
                send(CMD_COEF, 10'(i), rand_coef(), 16'($urandom));
        settle();
        apb_access(1'b1, REG_NUM_TAPS, {21'($urandom), 11'(value)});
        apb_access(1'b0, REG_NUM_TAPS, '0);
        taps_now = value;
        settings++;
    endtask

    initial begin
        tap_plan = '{1, 2047, 0, 0, 6, 1024, 17, 0, 2, 1025, 40, 0, 3, 1};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value, then writes outside the register map that must change nothing
        apb_access(1'b0, REG_NUM_TAPS, '0);
        apb_access(1'b1, REG_UNMAPPED_LO, $urandom);
        apb_access(1'b1, REG_UNMAPPED_HI, $urandom);
        apb_access(1'b0, REG_NUM_TAPS, '0);

        // extreme coefficients and samples over four taps
        send(CMD_COEF, 10'd0, 18'h1FFFF, 16'($urandom));
        send(CMD_COEF, 10'd1, 18'h20000, 16'($urandom));
        send(CMD_COEF, 10'd2, 18'h00000, 16'($urandom));
        send(CMD_COEF, 10'd3, 18'h10000, 16'($urandom));
        send(CMD_COEF, 10'd1023, 18'h3FFFF, 16'($urandom));
        set_taps(4);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h7FFF);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h7FFF);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h8000);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h8000);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h0000);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h0001);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'hFFFF);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h7FFF);
        // one live coefficient of one half: sums land exactly on the rounding boundary
        send(CMD_COEF, 10'd0, 18'h08000, 16'($urandom));
        send(CMD_COEF, 10'd1, 18'h00000, 16'($urandom));
        send(CMD_COEF, 10'd3, 18'h00000, 16'($urandom));
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h0001);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'hFFFF);
        send(CMD_SAMPLE, 10'($urandom), 18'($urandom), 16'h0003);

        for (int k = 0; k < 14; k++) begin
            n = (k % 4 == 3) ? $urandom_range(2, 80) : tap_plan[k];
            set_taps(n);
            eff   = (taps_now > MAX_TAPS) ? MAX_TAPS : taps_now;
            count = (eff >= 256) ? 10 : 50;
            calm  = (k == 13);
            for (int j = 0; j < count; j++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0 && eff > 0)
                    send(CMD_COEF, 10'($urandom_range(0, eff - 1)), rand_coef(),
                         16'($urandom));
                else if (pick <= 1)
                    send(CMD_COEF, 10'($urandom), rand_coef(), 16'($urandom));
                else
                    send(CMD_SAMPLE, 10'($urandom), 18'($urandom), rand_sample());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);

        if (pending != 0)
            $error("%0d filtered samples never came out", pending);
        $display("Sent %0d input transfers across %0d tap counts, from zero to past the store size.",
                 items, settings);
        $display("Checked %0d filtered samples, %0d of them clipped.", results, clipped);
        if (errors == 0 && pending == 0)
            $display("[fir_filter_direct_form_top] OK");
        else
            $display("[fir_filter_direct_form_top] ERROR");
        $finish;
    end

endmodule

/* fir_filter_direct_form_top.f */
design/fir_df_pkg.sv
design/fir_df_front.sv
design/fir_df_queue.sv
design/fir_df_back.sv
design/fir_filter_direct_form_top.sv
bench/fir_df_monitor.sv
bench/tb.sv
